// ===== rtl/acp_pkg.sv =====
// Shared types, constants and helper functions for the ASCII integer parser.
`default_nettype none

package acp_pkg;

    localparam int COUNT_BITS = 16;
    typedef logic [COUNT_BITS-1:0] count_t;
    localparam count_t COUNT_MAX = '1;

    localparam int VALUE_BITS = 64;
    typedef logic [VALUE_BITS-1:0] value_t;

    typedef enum logic [1:0] {
        BASE_AUTO = 2'd0,
        BASE_OCT  = 2'd1,
        BASE_DEC  = 2'd2,
        BASE_HEX  = 2'd3
    } base_mode_t;

    typedef enum logic [1:0] {
        REG_BASE_MODE  = 2'd0,
        REG_MAX_WIDTH  = 2'd1,
        REG_SIGN_EN    = 2'd2,
        REG_SKIP_SPACE = 2'd3
    } reg_index_t;

    typedef enum logic [4:0] {
        PH_SPACE  = 5'b00001,
        PH_FIRST  = 5'b00010,
        PH_ZERO   = 5'b00100,
        PH_XSEEN  = 5'b01000,
        PH_DIGITS = 5'b10000
    } phase_t;

    localparam logic [4:0] RADIX_8  = 5'd8;
    localparam logic [4:0] RADIX_10 = 5'd10;
    localparam logic [4:0] RADIX_16 = 5'd16;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DIG0  = 8'h30;
    localparam logic [7:0] CH_DIG9  = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;
    localparam logic [7:0] CH_LOA   = 8'h61;
    localparam logic [7:0] CH_LOZ   = 8'h7A;
    localparam logic [7:0] CH_UPX   = 8'h58;
    localparam logic [7:0] CH_LOX   = 8'h78;

    // Digit value of a character that is not a digit in any base.
    localparam logic [5:0] DIGIT_NONE = 6'd63;

    typedef struct packed {
        base_mode_t  base_mode;
        logic [15:0] max_width;
        logic        sign_en;
        logic        skip_space;
    } cfg_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } item_t;

    typedef struct packed {
        value_t value;
        logic   negative;
        logic   ok;
        count_t consumed;
    } result_t;

    function automatic logic is_white(input logic [7:0] c);
        return c == 8'd32 || c == 8'd9 || c == 8'd10 || c == 8'd13 ||
               c == 8'd12 || c == 8'd11;
    endfunction

    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CH_DIG0 && c <= CH_DIG9) begin
            d = c - CH_DIG0;
        end else if (c >= CH_LOA && c <= CH_LOZ) begin
            d = c - CH_LOA + 8'd10;
        end else if (c >= CH_UPA && c <= CH_UPZ) begin
            d = c - CH_UPA + 8'd10;
        end else begin
            d = {2'b00, DIGIT_NONE};
        end
        return d[5:0];
    endfunction

    function automatic count_t sat_add(input count_t a, input count_t b);
        logic [COUNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
    endfunction

    // Multiply by one of the three radix values using shifts, with one add for radix 10.
    function automatic value_t scale(input value_t a, input logic [4:0] radix);
        value_t r;
        case (radix)
            RADIX_8:  r = a << 3;
            RADIX_16: r = a << 4;
            default:  r = (a << 3) + (a << 1);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/acp_in_reg.sv =====
// Input register stage that holds one character between the stream and the parser.
`default_nettype none

module acp_in_reg
    import acp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] ch
    input  wire logic       s_tlast,
    input  wire logic       advance,
    output logic            item_valid,
    output item_t           item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.ch   <= s_tdata;
            item_reg.last <= s_tlast;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/acp_parse.sv =====
// Per-character parse state, its single-pass update and the result register.
`default_nettype none

module acp_parse
    import acp_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire logic  item_valid,
    input  wire item_t item,
    output logic       advance,
    output logic       result_valid,
    output result_t    result,
    input  wire logic  m_tready
);

    value_t     accum_reg, accum_next;
    value_t     neg_reg, neg_next;       // Running two's complement negation of accum.
    phase_t     phase_reg, phase_next;
    logic [4:0] base_reg, base_next;
    count_t     width_used_reg, width_used_next;
    count_t     char_count_reg, char_count_next;
    logic       minus_reg, minus_next;
    logic       digit_reg, digit_next;
    logic       finished_reg, finished_next;

    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, out_next;

    logic       consume;
    logic       end_of_text;

    assign advance      = !out_valid_reg || m_tready;
    assign consume      = item_valid && advance;
    assign end_of_text  = item.ch == CH_NUL || item.last;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb begin
        logic       can_take;
        logic       room;
        logic       go_sign;
        logic       go_first;
        logic       go_zero;
        logic       go_x;
        logic       go_dig;
        logic [5:0] d;
        logic [4:0] radix;
        count_t     cnt;

        accum_next      = accum_reg;
        neg_next        = neg_reg;
        phase_next      = phase_reg;
        base_next       = base_reg;
        width_used_next = width_used_reg;
        char_count_next = char_count_reg;
        minus_next      = minus_reg;
        digit_next      = digit_reg;
        finished_next   = finished_reg;

        go_sign  = 1'b0;
        go_first = 1'b0;
        go_zero  = 1'b0;
        go_x     = 1'b0;
        go_dig   = 1'b0;
        radix    = base_reg;
        d        = digit_of(item.ch);
        can_take = cfg.max_width == 16'd0 || width_used_reg < count_t'(cfg.max_width);
        room     = cfg.max_width == 16'd0 ||
                   ({1'b0, width_used_reg} + (COUNT_BITS+1)'(2)) <
                   (COUNT_BITS+1)'(cfg.max_width);

        // A zero byte ends the text without being taken.
        if (item.ch != CH_NUL && !finished_reg) begin
            unique case (phase_reg)
                PH_SPACE: begin
                    if (cfg.skip_space && is_white(item.ch)) begin
                        char_count_next = sat_add(char_count_reg, count_t'(1));
                    end else begin
                        go_sign = 1'b1;
                    end
                end
                PH_FIRST: go_first = 1'b1;
                PH_ZERO:  go_zero  = 1'b1;
                PH_XSEEN: go_x     = 1'b1;
                default:  go_dig   = 1'b1;
            endcase

            if (go_sign) begin
                phase_next = PH_FIRST;
                if (cfg.sign_en && can_take &&
                    (item.ch == CH_PLUS || item.ch == CH_MINUS)) begin
                    minus_next      = item.ch == CH_MINUS;
                    width_used_next = sat_add(width_used_reg, count_t'(1));
                end else begin
                    go_first = 1'b1;
                end
            end

            if (go_first) begin
                radix = (cfg.base_mode == BASE_OCT) ? RADIX_8 :
                        (cfg.base_mode == BASE_HEX) ? RADIX_16 : RADIX_10;
                if (can_take && item.ch == CH_DIG0 &&
                    (cfg.base_mode == BASE_AUTO || cfg.base_mode == BASE_HEX)) begin
                    if (cfg.base_mode == BASE_AUTO) begin
                        radix = RADIX_8;
                    end
                    accum_next      = '0;
                    neg_next        = '0;
                    digit_next      = 1'b1;
                    width_used_next = sat_add(width_used_reg, count_t'(1));
                    phase_next      = room ? PH_ZERO : PH_DIGITS;
                end else begin
                    go_dig = 1'b1;
                end
                base_next = radix;
            end

            if (go_zero) begin
                if (item.ch == CH_LOX || item.ch == CH_UPX) begin
                    phase_next = PH_XSEEN;
                end else begin
                    go_dig = 1'b1;
                end
            end

            if (go_x) begin
                if (d < 6'd16) begin
                    base_next       = RADIX_16;
                    accum_next      = value_t'(d);
                    neg_next        = '0 - value_t'(d);
                    width_used_next = sat_add(width_used_reg, count_t'(2));
                    phase_next      = PH_DIGITS;
                end else begin
                    finished_next = 1'b1;
                end
            end

            if (go_dig) begin
                phase_next = PH_DIGITS;
                if (can_take && d < {1'b0, radix}) begin
                    accum_next      = scale(accum_reg, radix) + value_t'(d);
                    neg_next        = scale(neg_reg, radix) - value_t'(d);
                    digit_next      = 1'b1;
                    width_used_next = sat_add(width_used_reg, count_t'(1));
                end else begin
                    finished_next = 1'b1;
                end
            end
        end

        cnt = digit_next ? sat_add(char_count_next, width_used_next) : char_count_next;
        out_next.value    = digit_next ? (minus_next ? neg_next : accum_next) : '0;
        out_next.negative = digit_next && minus_next;
        out_next.ok       = digit_next;
        out_next.consumed = cnt;

        if (end_of_text) begin
            accum_next      = '0;
            neg_next        = '0;
            phase_next      = PH_SPACE;
            base_next       = RADIX_10;
            width_used_next = '0;
            char_count_next = '0;
            minus_next      = 1'b0;
            digit_next      = 1'b0;
            finished_next   = 1'b0;
        end

        if (consume && end_of_text) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accum_reg      <= '0;
            neg_reg        <= '0;
            phase_reg      <= PH_SPACE;
            base_reg       <= RADIX_10;
            width_used_reg <= '0;
            char_count_reg <= '0;
            minus_reg      <= 1'b0;
            digit_reg      <= 1'b0;
            finished_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (consume) begin
                accum_reg      <= accum_next;
                neg_reg        <= neg_next;
                phase_reg      <= phase_next;
                base_reg       <= base_next;
                width_used_reg <= width_used_next;
                char_count_reg <= char_count_next;
                minus_reg      <= minus_next;
                digit_reg      <= digit_next;
                finished_reg   <= finished_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && end_of_text) begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ascii_integer_parser_core.sv =====
// m_tvalid rises once the text-ending item has passed the input and result registers.
// Throughput: one character per cycle; the input register and the result register
// each advance whenever the result register is empty or being read.
// Per character the logic is two parallel shift-and-add multiplies by 8, 10 or 16.
// Reset (aresetn, synchronous, active low) clears the parse state and both valid
// flags, and sets base mode 2, max width 0, sign enable 1, space skip 1.
`default_nettype none

module ascii_integer_parser_core
    import acp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // [63:0] value, [79:64] consumed
    output logic [1:0]       m_tuser    // [0] negative, [1] ok
);

    cfg_t    cfg_reg;
    logic    advance;
    logic    item_valid;
    item_t   item;
    result_t result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_mode  <= BASE_DEC;
            cfg_reg.max_width  <= 16'd0;
            cfg_reg.sign_en    <= 1'b1;
            cfg_reg.skip_space <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_index))
                REG_BASE_MODE:  cfg_reg.base_mode  <= base_mode_t'(cfg_wdata[1:0]);
                REG_MAX_WIDTH:  cfg_reg.max_width  <= cfg_wdata;
                REG_SIGN_EN:    cfg_reg.sign_en    <= cfg_wdata[0];
                REG_SKIP_SPACE: cfg_reg.skip_space <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    acp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    acp_parse u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .item_valid   (item_valid),
        .item         (item),
        .advance      (advance),
        .result_valid (m_tvalid),
        .result       (result),
        .m_tready     (m_tready)
    );

    assign m_tdata = {result.consumed, result.value};
    assign m_tuser = {result.ok, result.negative};

`ifndef SYNTHESIS
    // A failed parse carries neither a value nor a sign.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[1] |-> m_tdata[63:0] == 64'd0 && !m_tuser[0])
        else $error("result without digits carries a value or sign");

    // A successful parse has taken at least one character.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[79:64] != 16'd0)
        else $error("successful result reports nothing consumed");

    // With the result register empty, the input side must not stall.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result register is empty");

    // A result only appears after a transaction was held in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(item_valid))
        else $error("result appeared without an input transaction");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the ASCII integer parser core.
module tb
    import acp_pkg::*;
();

    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int LONG_HOLD    = 120;
    localparam int PHASE_ITEMS  = 100;
    localparam int RAND_PHASES  = 10;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum {SCAN_WS, SCAN_SIGN, SCAN_LEAD, SCAN_ZERO, SCAN_X, SCAN_DIGITS} scan_t;

    typedef struct {
        value_t value;
        logic   negative;
        logic   ok;
        count_t consumed;
    } parse_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic [1:0]  m_tuser;

    ascii_integer_parser_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #6 aclk = ~aclk;

    // Register copies kept alongside the block.
    base_mode_t  mode_r = BASE_DEC;
    logic [15:0] width_limit = '0;
    logic        sign_en = 1'b1;
    logic        skip_en = 1'b1;

    // Parse state of the current text.
    value_t      p_accum;
    scan_t       p_scan;
    int unsigned p_radix;
    int unsigned p_used;
    int unsigned p_chars;
    bit          p_minus;
    bit          p_digit;
    bit          p_done;

    item_t         pending_chars[$];
    parse_result_t expected_results[$];

    int  queued_items;
    int  errors;
    int  cycle_cnt;
    int  gap_left;
    int  stall_left;
    int  hold_left;
    int  hold_asked;
    int  hold_served;
    bit  calm;
    logic in_taken = 1'b0;
    item_t next_item;
    parse_result_t want_r;

    function automatic int unsigned sat_count(input int unsigned a, input int unsigned b);
        int unsigned s;
        s = a + b;
        return (s > COUNT_MAX) ? COUNT_MAX : s;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic int unsigned char_digit(input logic [7:0] c);
        if (c >= CH_DIG0 && c <= CH_DIG9) return c - CH_DIG0;
        if (c >= CH_LOA && c <= CH_LOZ) return c - CH_LOA + 10;
        if (c >= CH_UPA && c <= CH_UPZ) return c - CH_UPA + 10;
        return 99;
    endfunction

    function automatic bit width_ok();
        return width_limit == 0 || p_used < width_limit;
    endfunction

    function automatic void clear_parse();
        p_accum = '0;
        p_scan  = SCAN_WS;
        p_radix = 10;
        p_used  = 0;
        p_chars = 0;
        p_minus = 1'b0;
        p_digit = 1'b0;
        p_done  = 1'b0;
    endfunction

    function automatic void parse_char(input logic [7:0] c);
        int unsigned d;
        bit fits;
        if (p_done) return;
        if (p_scan == SCAN_WS) begin
            if (skip_en && is_blank(c)) begin
                p_chars = sat_count(p_chars, 1);
                return;
            end
            p_scan = SCAN_SIGN;
        end
        if (p_scan == SCAN_SIGN) begin
            p_scan = SCAN_LEAD;
            if (sign_en && width_ok() && (c == CH_PLUS || c == CH_MINUS)) begin
                p_minus = (c == CH_MINUS);
                p_used = sat_count(p_used, 1);
                return;
            end
        end
        if (p_scan == SCAN_LEAD) begin
            p_radix = (mode_r == BASE_OCT) ? 8 : (mode_r == BASE_HEX) ? 16 : 10;
            if (width_ok() && c == CH_DIG0 && (mode_r == BASE_AUTO || mode_r == BASE_HEX)) begin
                // The prefix needs room for the 0, the x and one hex digit.
                fits = (width_limit == 0) || (p_used + 2 < width_limit);
                if (mode_r == BASE_AUTO) p_radix = 8;
                p_accum = '0;
                p_digit = 1'b1;
                p_used = sat_count(p_used, 1);
                p_scan = fits ? SCAN_ZERO : SCAN_DIGITS;
                return;
            end
            p_scan = SCAN_DIGITS;
        end
        if (p_scan == SCAN_ZERO) begin
            if (c == CH_LOX || c == CH_UPX) begin
                p_scan = SCAN_X;
                return;
            end
            p_scan = SCAN_DIGITS;
        end
        if (p_scan == SCAN_X) begin
            // The x only counts once a hex digit follows it.
            d = char_digit(c);
            if (d < 16) begin
                p_radix = 16;
                p_accum = d;
                p_used = sat_count(p_used, 2);
                p_scan = SCAN_DIGITS;
            end else begin
                p_done = 1'b1;
            end
            return;
        end
        d = char_digit(c);
        if (width_ok() && d < p_radix) begin
            p_accum = p_accum * p_radix + d;
            p_digit = 1'b1;
            p_used = sat_count(p_used, 1);
        end else begin
            p_done = 1'b1;
        end
    endfunction

    function automatic parse_result_t end_text();
        parse_result_t r;
        r.value    = p_digit ? (p_minus ? -p_accum : p_accum) : '0;
        r.negative = p_digit && p_minus;
        r.ok       = p_digit;
        r.consumed = count_t'(p_digit ? sat_count(p_chars, p_used) : p_chars);
        clear_parse();
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function automatic void push_char(input logic [7:0] c);
        item_t it;
        it.ch = c;
        it.last = 1'b0;
        pending_chars.push_back(it);
        queued_items++;
    endfunction

    function automatic void push_str(input string s, input bit nul_end);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
        if (nul_end) push_char(CH_NUL);
        else pending_chars[$].last = 1'b1;
    endfunction

    // One random text: mostly well-formed numbers, some plain byte noise.
    function automatic void gen_text();
        int start;
        int ndig;
        int unsigned dv;
        bit hexy;
        start = queued_items;
        hexy = (mode_r == BASE_HEX);
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) push_char(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 3)) begin
                dv = $urandom_range(0, 5);
                push_char((dv == 0) ? CH_SPACE : 8'(CH_TAB + dv - 1));
            end
            case ($urandom_range(0, 3))
                1: push_char(CH_PLUS);
                2: push_char(CH_MINUS);
                default: ;
            endcase
            case ($urandom_range(0, 4))
                0: push_char(CH_DIG0);
                1: begin
                    push_char(CH_DIG0);
                    push_char(CH_LOX);
                    hexy = 1'b1;
                end
                2: begin
                    push_char(CH_DIG0);
                    push_char(CH_UPX);
                    hexy = 1'b1;
                end
                default: ;
            endcase
            ndig = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 24) : $urandom_range(0, 6);
            repeat (ndig) begin
                if ($urandom_range(0, 7) == 0) dv = $urandom_range(0, 35);
                else dv = $urandom_range(0, hexy ? 15 : 9);
                if (dv < 10) push_char(8'(CH_DIG0 + dv));
                else push_char(8'(($urandom_range(0, 1) ? CH_LOA : CH_UPA) + dv - 10));
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 3)) push_char(8'($urandom_range(1, 255)));
            end
        end
        if (queued_items == start || $urandom_range(0, 2) == 0) begin
            push_char(CH_NUL);
            pending_chars[$].last = 1'($urandom_range(0, 1));
        end else begin
            pending_chars[$].last = 1'b1;
        end
    endfunction

    task automatic write_reg(input reg_index_t idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        case (idx)
            REG_BASE_MODE:  mode_r = base_mode_t'(data[1:0]);
            REG_MAX_WIDTH:  width_limit = data;
            REG_SIGN_EN:    sign_en = data[0];
            REG_SKIP_SPACE: skip_en = data[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        @(posedge aclk);
    endtask

    // Holds off until every queued character is sent and every result is back.
    task automatic wait_idle();
        while (pending_chars.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Sender: presents the next queued character once the current one is taken.
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || in_taken)) begin
            if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                s_tvalid <= 1'b0;
                gap_left <= $urandom_range(0, 6);
            end else if (pending_chars.size() != 0) begin
                next_item = pending_chars.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_item.ch;
                s_tlast  <= next_item.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure plus requested long hold-offs.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            m_tready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_served <= hold_served + 1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_cnt = cycle_cnt + 1;
        in_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            if (s_tdata != CH_NUL) parse_char(s_tdata);
            if (s_tdata == CH_NUL || s_tlast) expected_results.push_back(end_text());
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, %s %0h tuser %b consumed %0d",
                         $time, "actual value", m_tdata[63:0], m_tuser, m_tdata[79:64]);
            end else begin
                want_r = expected_results.pop_front();
                check_field("value", want_r.value, m_tdata[63:0]);
                check_field("negative", want_r.negative, m_tuser[0]);
                check_field("ok", want_r.ok, m_tuser[1]);
                check_field("consumed", want_r.consumed, m_tdata[79:64]);
            end
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int ph;
        logic [15:0] wv;
        clear_parse();
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed texts, first under the reset settings.
        push_char(CH_NUL);
        push_str(" -42", 1'b0);
        push_str("+", 1'b0);
        push_char(8'hFF);
        pending_chars[$].last = 1'b1;
        wait_idle();
        write_reg(REG_BASE_MODE, 16'(BASE_AUTO));
        push_str("0x1F", 1'b0);
        push_str("0xg", 1'b1);
        push_str("017", 1'b0);
        wait_idle();
        write_reg(REG_BASE_MODE, 16'(BASE_HEX));
        write_reg(REG_MAX_WIDTH, 16'd2);
        push_str("0x5", 1'b0);
        wait_idle();
        write_reg(REG_SIGN_EN, 16'd0);
        write_reg(REG_SKIP_SPACE, 16'd0);
        write_reg(REG_MAX_WIDTH, 16'd0);
        write_reg(REG_BASE_MODE, 16'(BASE_DEC));
        push_str(" 5", 1'b0);
        push_str("-5", 1'b0);

        for (ph = 0; ph < RAND_PHASES; ph++) begin
            wait_idle();
            wv = 16'($urandom);
            wv[1:0] = ph[1:0];
            write_reg(REG_BASE_MODE, wv);
            case (ph % 5)
                0: wv = 16'd0;
                1: wv = 16'hFFFF;
                2: wv = 16'($urandom_range(1, 3));
                3: wv = 16'($urandom_range(4, 24));
                default: wv = 16'($urandom);
            endcase
            write_reg(REG_MAX_WIDTH, wv);
            write_reg(REG_SIGN_EN, 16'($urandom));
            write_reg(REG_SKIP_SPACE, 16'($urandom));
            queued_items = 0;
            while (queued_items < PHASE_ITEMS) gen_text();
            // Stall the result side long enough for the input to back up.
            if (ph == 4) hold_asked++;
        end

        wait_idle();
        calm = 1'b1;
        write_reg(REG_BASE_MODE, 16'(BASE_DEC));
        write_reg(REG_MAX_WIDTH, 16'd0);
        write_reg(REG_SIGN_EN, 16'd1);
        write_reg(REG_SKIP_SPACE, 16'd1);
        push_str("  12", 1'b0);
        queued_items = 0;
        while (queued_items < 50) gen_text();

        wait_idle();
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/acp_pkg.sv
rtl/acp_in_reg.sv
rtl/acp_parse.sv
rtl/ascii_integer_parser_core.sv
tb/sv/tb.sv
